// ===== hw/rtl/mce_pkg.sv =====
// shared types, constants and the morse code lookup for the character encoder
// no dependencies
package mce_pkg;

   // symbol codes on the result channel
   typedef enum logic [2:0] {
      SYM_DIT   = 3'd0,
      SYM_DAH   = 3'd1,
      SYM_SHORT = 3'd2,
      SYM_LGAP  = 3'd3,
      SYM_WGAP  = 3'd4
   } symbol_type;

   // configuration register indexes
   localparam logic [1:0] CSR_DIT_EN   = 2'd0;
   localparam logic [1:0] CSR_DAH_EN   = 2'd1;
   localparam logic [1:0] CSR_LGAP_EN  = 2'd2;
   localparam logic [1:0] CSR_WGAP_EN  = 2'd3;

   localparam logic [7:0] LEAD_LIMIT = 8'h80;
   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam logic [7:0] UPPER_A    = 8'h41;
   localparam logic [7:0] LOWER_A    = 8'h61;
   localparam logic [7:0] DIGIT_0    = 8'h30;

   localparam int unsigned MAX_ELEMS = 7;   // longest morse pattern
   localparam int unsigned SLOTS     = 8;   // pattern elements plus the gap slot

   typedef struct packed {
      logic [7:0] char_byte;
      logic       text_start;
   } req_type;

   typedef struct packed {
      logic [2:0] symbol;
      logic       run_last;
   } rsp_type;

   // one morse pattern: element i is a dah when dahs[i] is set
   typedef struct packed {
      logic       short_flag;
      logic [2:0] len;
      logic [MAX_ELEMS-1:0] dahs;
   } code_type;

   typedef struct packed {
      logic load;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic slots_empty;
      logic out_free;
      logic step_last;
   } sts_type;

   localparam code_type LETTER_CODES [26] = '{
      '{1'b0, 3'd2, 7'b0000010},   // a
      '{1'b0, 3'd4, 7'b0000001},   // b
      '{1'b0, 3'd4, 7'b0000101},   // c
      '{1'b0, 3'd3, 7'b0000001},   // d
      '{1'b0, 3'd1, 7'b0000000},   // e
      '{1'b0, 3'd4, 7'b0000100},   // f
      '{1'b0, 3'd3, 7'b0000011},   // g
      '{1'b0, 3'd4, 7'b0000000},   // h
      '{1'b0, 3'd2, 7'b0000000},   // i
      '{1'b0, 3'd4, 7'b0001110},   // j
      '{1'b0, 3'd3, 7'b0000101},   // k
      '{1'b0, 3'd4, 7'b0000010},   // l
      '{1'b0, 3'd2, 7'b0000011},   // m
      '{1'b0, 3'd2, 7'b0000001},   // n
      '{1'b0, 3'd3, 7'b0000111},   // o
      '{1'b0, 3'd4, 7'b0000110},   // p
      '{1'b0, 3'd4, 7'b0001011},   // q
      '{1'b0, 3'd3, 7'b0000010},   // r
      '{1'b0, 3'd3, 7'b0000000},   // s
      '{1'b0, 3'd1, 7'b0000001},   // t
      '{1'b0, 3'd3, 7'b0000100},   // u
      '{1'b0, 3'd4, 7'b0001000},   // v
      '{1'b0, 3'd3, 7'b0000110},   // w
      '{1'b0, 3'd4, 7'b0001001},   // x
      '{1'b0, 3'd4, 7'b0001101},   // y
      '{1'b0, 3'd4, 7'b0000011}    // z
   };

   localparam code_type DIGIT_CODES [10] = '{
      '{1'b0, 3'd5, 7'b0011111},
      '{1'b0, 3'd5, 7'b0011110},
      '{1'b0, 3'd5, 7'b0011100},
      '{1'b0, 3'd5, 7'b0011000},
      '{1'b0, 3'd5, 7'b0010000},
      '{1'b0, 3'd5, 7'b0000000},
      '{1'b0, 3'd5, 7'b0000001},
      '{1'b0, 3'd5, 7'b0000011},
      '{1'b0, 3'd5, 7'b0000111},
      '{1'b0, 3'd5, 7'b0001111}
   };

   function automatic code_type code_lookup(input logic [7:0] b);
      code_type   c;
      logic [7:0] off;
      c   = '{1'b0, 3'd0, 7'b0000000};
      off = 8'd0;
      case (b) inside
         [8'h41:8'h5A]: begin
            off = b - UPPER_A;
            c   = LETTER_CODES[off[4:0]];
         end
         [8'h61:8'h7A]: begin
            off = b - LOWER_A;
            c   = LETTER_CODES[off[4:0]];
         end
         [8'h30:8'h39]: begin
            off = b - DIGIT_0;
            c   = DIGIT_CODES[off[3:0]];
         end
         8'h84, 8'hA4: c = '{1'b0, 3'd4, 7'b0001010};
         8'h96, 8'hB6: c = '{1'b0, 3'd4, 7'b0000111};
         8'h9C, 8'hBC: c = '{1'b0, 3'd4, 7'b0001100};
         8'h9F:        c = '{1'b0, 3'd7, 7'b0011000};
         8'h2E:        c = '{1'b0, 3'd6, 7'b0101010};
         8'h2C:        c = '{1'b0, 3'd6, 7'b0110011};
         8'h3A:        c = '{1'b0, 3'd6, 7'b0000111};
         8'h3B:        c = '{1'b0, 3'd6, 7'b0010101};
         8'h3F:        c = '{1'b0, 3'd6, 7'b0001100};
         8'h21:        c = '{1'b0, 3'd6, 7'b0110101};
         8'h2D:        c = '{1'b0, 3'd6, 7'b0100001};
         8'h5F:        c = '{1'b0, 3'd6, 7'b0101100};
         8'h28:        c = '{1'b0, 3'd5, 7'b0001101};
         8'h29:        c = '{1'b0, 3'd6, 7'b0101101};
         8'h27:        c = '{1'b0, 3'd6, 7'b0011110};
         8'h22:        c = '{1'b1, 3'd1, 7'b0000000};
         8'h3D:        c = '{1'b0, 3'd5, 7'b0010001};
         8'h2B:        c = '{1'b0, 3'd5, 7'b0001010};
         8'h2F:        c = '{1'b0, 3'd5, 7'b0001001};
         8'h40:        c = '{1'b0, 3'd6, 7'b0010110};
         default:      c = '{1'b0, 3'd0, 7'b0000000};
      endcase
      return c;
   endfunction

endpackage

// ===== hw/rtl/mce_ctrl.sv =====
// sequencer for the character encoder: takes a byte, then steps out its symbols
// depends on mce_pkg
module mce_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output mce_pkg::cmd_type cmd,
   input  mce_pkg::sts_type sts
);
   import mce_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '{load: 1'b0, step: 1'b0};
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (sts.slots_empty) begin
               // lead byte or everything disabled
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.step = 1'b1;
               if (sts.step_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/mce_dpath.sv =====
// datapath of the character encoder: enables, lead-byte flag, symbol slots, output word
// depends on mce_pkg
module mce_dpath (
   input  logic             clock,
   input  logic             reset,
   input  mce_pkg::req_type req_data,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output mce_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_index,
   input  logic             csr_wr_data,
   input  mce_pkg::cmd_type cmd,
   output mce_pkg::sts_type sts
);
   import mce_pkg::*;

   logic dit_en_ff, dah_en_ff, lgap_en_ff, wgap_en_ff;
   logic pending_ff, pending_in;
   logic [SLOTS-1:0] slots_ff, slots_in;
   logic [MAX_ELEMS-1:0] dahs_ff;
   logic short_ff, space_ff;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   code_type   code;
   logic       pend_eff;
   logic       is_lead;
   logic [SLOTS-1:0] load_slots;
   logic [SLOTS-1:0] rest_slots;
   logic [2:0] pick;
   symbol_type pick_sym;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dit_en_ff  <= 1'b1;
         dah_en_ff  <= 1'b1;
         lgap_en_ff <= 1'b1;
         wgap_en_ff <= 1'b1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_DIT_EN:  dit_en_ff  <= csr_wr_data;
            CSR_DAH_EN:  dah_en_ff  <= csr_wr_data;
            CSR_LGAP_EN: lgap_en_ff <= csr_wr_data;
            CSR_WGAP_EN: wgap_en_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // slot mask at load: one bit per symbol that will be sent, gap in the top slot
   always_comb begin
      code     = code_lookup(req_data.char_byte);
      pend_eff = pending_ff && !req_data.text_start;
      is_lead  = !pend_eff && (req_data.char_byte > LEAD_LIMIT);
      for (int i = 0; i < MAX_ELEMS; i++) begin
         load_slots[i] = (3'(i) < code.len) &&
                         (code.dahs[i] ? dah_en_ff : dit_en_ff);
      end
      load_slots[SLOTS-1] = (req_data.char_byte == SPACE_CHAR) ? wgap_en_ff : lgap_en_ff;
      if (is_lead) begin
         load_slots = '0;
      end
   end

   // lowest pending slot goes out next
   always_comb begin
      pick = 3'd0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (slots_ff[i]) begin
            pick = 3'(i);
         end
      end
      rest_slots       = slots_ff;
      rest_slots[pick] = 1'b0;
      if (pick == 3'(SLOTS - 1)) begin
         pick_sym = space_ff ? SYM_WGAP : SYM_LGAP;
      end else if (short_ff) begin
         pick_sym = SYM_SHORT;
      end else begin
         pick_sym = dahs_ff[pick] ? SYM_DAH : SYM_DIT;
      end
   end

   always_comb begin
      pending_in   = pending_ff;
      slots_in     = slots_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (cmd.load) begin
         pending_in = is_lead;
         slots_in   = load_slots;
      end
      if (cmd.step) begin
         slots_in     = rest_slots;
         rsp_valid_in = 1'b1;
         rsp_data_in  = '{symbol: pick_sym, run_last: (rest_slots == '0)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 1'b0;
         slots_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         slots_ff     <= slots_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (cmd.load) begin
         dahs_ff  <= code.dahs;
         short_ff <= code.short_flag;
         space_ff <= (req_data.char_byte == SPACE_CHAR);
      end
   end

   assign sts.slots_empty = (slots_ff == '0);
   assign sts.out_free    = !rsp_valid_ff || !rsp_stall;
   assign sts.step_last   = (rest_slots == '0);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/morse_character_encoder.sv =====
// top level of the morse character encoder
// depends on mce_pkg, mce_ctrl and mce_dpath
//
// takes one text byte per word on the req channel and sends its morse symbols
// on the rsp channel, one symbol per word: dits and dahs in order, then a
// letter gap, or only a word gap for a space. letters are case-insensitive;
// digits, umlauts, sharp s and common punctuation are covered, and a quotation
// mark gives one short dit. with no lead byte pending, a byte above 0x80 is a
// utf-8 lead: it is swallowed and the next byte is encoded as it stands.
// text_start drops a pending lead. unknown bytes give only the letter gap.
// each symbol kind has an enable (csr index 0 dit and short dit, 1 dah,
// 2 letter gap, 3 word gap, all set after reset); disabled symbols are
// skipped, so a byte may give no words at all. run_last marks the final
// symbol of a byte.
// timing: a byte is taken, then the sequencer sends one symbol per cycle
// through the output register while the rsp channel does not stall; a stall
// holds the sequencer, and no new byte is taken until the last symbol of a
// byte has been stepped out. that last symbol may still wait in the output
// register while the next byte is taken.
module morse_character_encoder (
   input  logic             clock,
   input  logic             reset,
   // text bytes in
   input  logic             req_valid,
   output logic             req_stall,
   input  mce_pkg::req_type req_data,
   // symbols out
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mce_pkg::rsp_type rsp_data,
   // symbol enables
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_index,
   input  logic             csr_wr_data
);
   import mce_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer: idle until a byte comes, then one symbol per free output slot
   mce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // code lookup, lead-byte tracking, slot mask and output register
   mce_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule
